FILE: design/alist_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alist_pkg
// Shared types for the array list: operation codes, status codes and the
// per-cycle control that the cell row receives.
// ----------------------------------------------------------------------------
package alist_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 4;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_REM_FRONT = 4'd3,
        OP_REM_BACK  = 4'd4,
        OP_REM_AT    = 4'd5,
        OP_RD_FRONT  = 4'd6,
        OP_RD_BACK   = 4'd7,
        OP_RD_AT     = 4'd8
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    // ins_en: cells at/after the position shift up, the cell at it loads.
    // rem_en: cells at/after the position take their upper neighbor.
    typedef struct packed {
        logic ins_en;
        logic rem_en;
    } t_cell_ctrl;

endpackage
`default_nettype wire

FILE: design/array_list_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// array_list_insert_remove
// Ordered list of up to CAPACITY signed 32-bit values with insert, remove and
// read at the front, the back or a position.
//
// Input channel (i_valid/o_ready) carries one operation per transfer; the
// output channel (o_valid/i_ready) returns one result per operation with a
// status, the removed or read value and the entry count after the operation.
// The whole operation, including the shift of every entry, happens in the
// row of cells at the edge where the input transfer completes; the result is
// registered and appears in the next cycle. One operation per cycle is taken
// as long as the receiver keeps up: the result register is the only stage.
// When the receiver stalls, the result holds and o_ready drops until it is
// taken. Reset empties the list (count zero); cell contents are not cleared
// and are never visible since only entries below the count are read.
// Errors (full, empty, position out of range) leave the list untouched.
// Codes 9 to 15 are no-ops that return status ok, value zero.
// ----------------------------------------------------------------------------
module array_list_insert_remove
    import alist_pkg::*;
#(
    parameter int CAPACITY = 64,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_ready,
    input  wire logic [OP_W-1:0]          i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic [CNT_W-1:0]         i_position,
    output logic                          o_valid,
    input  wire logic                     i_ready,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_value_out,
    output logic [CNT_W-1:0]              o_count
);

    localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

    logic                     r_valid;
    logic [CNT_W-1:0]         r_count;
    t_status                  r_status;
    logic signed [DATA_W-1:0] r_value;

    logic                     n_valid;
    logic [CNT_W-1:0]         n_count;
    t_status                  n_status;
    logic signed [DATA_W-1:0] n_value;

    logic                     w_accept;
    logic [CNT_W-1:0]         w_where;
    t_cell_ctrl               w_ctrl;
    t_cell_ctrl               w_cell_ctrl;
    logic signed [DATA_W-1:0] w_sel_data;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Position each operation acts on.
    always_comb begin
        unique case (t_op'(i_operation))
            OP_INS_FRONT, OP_REM_FRONT, OP_RD_FRONT: w_where = '0;
            OP_INS_BACK:                             w_where = r_count;
            OP_REM_BACK, OP_RD_BACK:                 w_where = r_count - CNT_W'(1);
            OP_INS_AT, OP_REM_AT, OP_RD_AT:          w_where = i_position;
            default:                                 w_where = '0;
        endcase
    end

    always_comb begin
        n_status = ST_OK;
        n_value  = '0;
        n_count  = r_count;
        w_ctrl   = '0;
        unique case (t_op'(i_operation))
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (r_count == CAP_V) begin
                    n_status = ST_FULL;
                end else if (w_where > r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    w_ctrl.ins_en = 1'b1;
                    n_count       = r_count + CNT_W'(1);
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_where >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_value       = w_sel_data;
                    w_ctrl.rem_en = 1'b1;
                    n_count       = r_count - CNT_W'(1);
                end
            end
            OP_RD_FRONT, OP_RD_BACK, OP_RD_AT: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (w_where >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_value = w_sel_data;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    assign w_cell_ctrl = w_accept ? w_ctrl : '0;

    alist_chain #(
        .CAPACITY (CAPACITY),
        .IDX_W    (CNT_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_cell_ctrl),
        .i_pos       (w_where),
        .i_ins_value (i_value),
        .o_sel_data  (w_sel_data)
    );

    assign n_valid = w_accept || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status <= n_status;
            r_value  <= n_value;
        end
    end

    // Count only moves with an input transfer, which also replaces the result.
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_out = r_value;
    assign o_count     = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_V)
        else $error("entry count above capacity");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without a transfer");

    a_err_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (n_status != ST_OK)) |=> (r_count == $past(r_count)))
        else $error("failed operation changed the count");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_valid)
        else $error("transfer produced no result");

endmodule
`default_nettype wire

FILE: design/alist_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alist_cell
// One list entry. Loads from its lower neighbor, its upper neighbor or the
// insert value, depending on where it sits relative to the operation position.
// ----------------------------------------------------------------------------
module alist_cell
    import alist_pkg::*;
#(
    parameter int IDX_W = 7,
    parameter int IDX   = 0
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire logic [IDX_W-1:0]         i_pos,
    input  wire logic signed [DATA_W-1:0] i_ins_value,
    input  wire logic signed [DATA_W-1:0] i_lower,
    input  wire logic signed [DATA_W-1:0] i_upper,
    output logic signed [DATA_W-1:0]      o_data,
    output logic signed [DATA_W-1:0]      o_tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctrl.ins_en) begin
            if (MY_IDX > i_pos) begin
                n_data = i_lower;
            end else if (MY_IDX == i_pos) begin
                n_data = i_ins_value;
            end
        end else if (i_ctrl.rem_en && (MY_IDX >= i_pos)) begin
            n_data = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_tap  = (MY_IDX == i_pos) ? r_data : '0;

endmodule
`default_nettype wire

FILE: design/alist_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alist_chain
// Row of list cells linked to both neighbors, plus the OR bus that returns
// the entry at the selected position.
// ----------------------------------------------------------------------------
module alist_chain
    import alist_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = 7
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire logic [IDX_W-1:0]         i_pos,
    input  wire logic signed [DATA_W-1:0] i_ins_value,
    output logic signed [DATA_W-1:0]      o_sel_data
);

    logic signed [DATA_W-1:0] w_data [CAPACITY];
    logic signed [DATA_W-1:0] w_tap  [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] w_lower;
        logic signed [DATA_W-1:0] w_upper;

        // End cells: the front never shifts up from below, the back has
        // nothing above it to pull down.
        if (g == 0) begin : g_front
            assign w_lower = i_ins_value;
        end else begin : g_mid_lo
            assign w_lower = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_back
            assign w_upper = w_data[g];
        end else begin : g_mid_hi
            assign w_upper = w_data[g+1];
        end

        alist_cell #(
            .IDX_W (IDX_W),
            .IDX   (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (i_ctrl),
            .i_pos       (i_pos),
            .i_ins_value (i_ins_value),
            .i_lower     (w_lower),
            .i_upper     (w_upper),
            .o_data      (w_data[g]),
            .o_tap       (w_tap[g])
        );
    end

    always_comb begin
        o_sel_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            o_sel_data = o_sel_data | w_tap[i];
        end
    end

endmodule
`default_nettype wire

FILE: dv/array_list_insert_remove_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_insert_remove_test
// Self-checking bench for the array list. A shadow list predicts status, value
// and count for every operation taken; results are checked in order. Directed
// tests hit the empty, full and position-range cases and a long output stall,
// then a long random run grows and shrinks the list, with random gaps.
// ----------------------------------------------------------------------------
module array_list_insert_remove_test;
    import alist_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int N_RANDOM   = 1330;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int TAIL_CYCLES = 10;

    // codes outside the decoded set; the block treats them as no-ops
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

    typedef struct {
        logic [1:0]        status;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_ready;
    logic [OP_W-1:0]          i_operation;
    logic signed [DATA_W-1:0] i_value;
    logic [CNT_W-1:0]         i_position;
    logic                     o_valid;
    logic                     i_ready;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_value_out;
    logic [CNT_W-1:0]         o_count;

    // shadow copy of the list
    logic [DATA_W-1:0] shadow_cells [CAPACITY];
    int unsigned       shadow_len;

    t_list_result pending_results [$];

    int  fail_count;
    int  checked_count;
    int  status_seen [4];
    int  longest_list;
    int  idle_cycles;
    bit  steady_mode;
    bit  hold_req;
    bit  hold_active;
    int  hold_done;
    int  rx_stall;

    array_list_insert_remove #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_operation (i_operation),
        .i_value     (i_value),
        .i_position  (i_position),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Apply one operation to the shadow list and return the expected result.
    function automatic t_list_result list_apply_op(logic [OP_W-1:0] op,
                                                   logic [DATA_W-1:0] val,
                                                   logic [CNT_W-1:0] pos);
        t_list_result r;
        int unsigned  where;
        bit           is_insert;
        bit           is_remove;
        bit           is_read;
        r.status  = ST_OK;
        r.value   = '0;
        is_insert = 1'b0;
        is_remove = 1'b0;
        is_read   = 1'b0;
        where     = 0;
        case (op)
            OP_INS_FRONT: begin is_insert = 1'b1; where = 0; end
            OP_INS_BACK:  begin is_insert = 1'b1; where = shadow_len; end
            OP_INS_AT:    begin is_insert = 1'b1; where = 32'(pos); end
            OP_REM_FRONT: begin is_remove = 1'b1; where = 0; end
            OP_REM_BACK:  begin is_remove = 1'b1; where = shadow_len - 1; end
            OP_REM_AT:    begin is_remove = 1'b1; where = 32'(pos); end
            OP_RD_FRONT:  begin is_read = 1'b1; where = 0; end
            OP_RD_BACK:   begin is_read = 1'b1; where = shadow_len - 1; end
            OP_RD_AT:     begin is_read = 1'b1; where = 32'(pos); end
            default: ;
        endcase
        if (is_insert) begin
            if (shadow_len >= CAPACITY) begin
                r.status = ST_FULL;
            end else if (where > shadow_len) begin
                r.status = ST_RANGE;
            end else begin
                for (int i = shadow_len; i > where; i--) begin
                    shadow_cells[i] = shadow_cells[i-1];
                end
                shadow_cells[where] = val;
                shadow_len++;
            end
        end else if (is_remove || is_read) begin
            if (shadow_len == 0) begin
                r.status = ST_EMPTY;
            end else if (where >= shadow_len) begin
                r.status = ST_RANGE;
            end else begin
                r.value = shadow_cells[where];
                if (is_remove) begin
                    for (int i = where; i + 1 < shadow_len; i++) begin
                        shadow_cells[i] = shadow_cells[i+1];
                    end
                    shadow_len--;
                end
            end
        end
        r.count = shadow_len[CNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_mode || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output check first (it belongs to an earlier operation), then predict
    // the operation taken at this edge.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result with no operation pending: status %0d value %0d count %0d",
                           o_status, o_value_out, o_count);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    checked_count++;
                    status_seen[o_status]++;
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fail_count++;
                    end
                    if (o_value_out !== want.value) begin
                        $error("value_out: expected %0d, got %0d",
                               $signed(want.value), o_value_out);
                        fail_count++;
                    end
                    if (o_count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, o_count);
                        fail_count++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                pending_results.push_back(list_apply_op(i_operation, i_value, i_position));
                if (shadow_len > longest_list) longest_list = shadow_len;
            end
        end
    end

    // Watchdog: cycles with no transfer on either channel.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: random ready with short and long stalls, plus the long hold-off.
    initial begin
        i_ready  = 1'b0;
        rx_stall = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_active = 1'b1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done += HOLD_CYCLES;
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end else if (rx_stall > 0) begin
                i_ready <= 1'b0;
                rx_stall--;
            end else if (steady_mode || $urandom_range(0, 99) < 70) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b0;
                rx_stall = pick_gap();
            end
        end
    end

    // Caller sits at a falling edge; returns at a falling edge after the gap.
    task automatic send_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val,
                           logic [CNT_W-1:0] pos);
        int gap;
        i_valid     <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        i_position  <= pos;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_op(OP_REM_FRONT, 32'h0, '0);
        send_op(OP_REM_BACK, 32'h0, '0);
        send_op(OP_REM_AT, 32'h0, 7'd0);
        send_op(OP_RD_FRONT, 32'h0, '0);
        send_op(OP_RD_BACK, 32'h0, '0);
        send_op(OP_RD_AT, 32'h0, 7'd127);
        send_op(OP_INS_AT, 32'h1234_5678, 7'd1);
        send_op(OP_UNUSED_LO, 32'hdead_beef, 7'd5);
        send_op(OP_UNUSED_HI, 32'hffff_ffff, 7'd127);
    endtask

    task automatic test_edge_positions();
        send_op(OP_INS_AT, 32'h7fff_ffff, 7'd0);
        send_op(OP_INS_FRONT, 32'h8000_0000, '0);
        send_op(OP_INS_BACK, 32'hffff_ffff, '0);
        send_op(OP_INS_AT, 32'h0, 7'd3);        // at count: append
        send_op(OP_INS_AT, 32'h5555_aaaa, 7'd5); // past count
        send_op(OP_INS_AT, 32'haaaa_5555, 7'd2);
        send_op(OP_RD_FRONT, 32'h0, '0);
        send_op(OP_RD_BACK, 32'h0, '0);
        send_op(OP_RD_AT, 32'h0, 7'd4);
        send_op(OP_RD_AT, 32'h0, 7'd5);         // at count: out of range
        send_op(OP_REM_AT, 32'h0, 7'd127);
        send_op(OP_UNUSED_LO, 32'h1, 7'd1);
        send_op(OP_REM_AT, 32'h0, 7'd1);
        send_op(OP_REM_BACK, 32'h0, '0);
        send_op(OP_REM_FRONT, 32'h0, '0);
    endtask

    task automatic test_full_list();
        while (shadow_len < CAPACITY) begin
            send_op(OP_INS_AT, pick_value(), CNT_W'($urandom_range(0, shadow_len)));
        end
        // full takes precedence over the position check
        send_op(OP_INS_FRONT, 32'h1, '0);
        send_op(OP_INS_BACK, 32'h2, '0);
        send_op(OP_INS_AT, 32'h3, 7'd100);
        send_op(OP_RD_AT, 32'h0, 7'd63);
        send_op(OP_RD_AT, 32'h0, 7'd64);
        send_op(OP_REM_BACK, 32'h0, '0);
        send_op(OP_INS_AT, 32'h4, 7'd63);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        wait (hold_active);
        steady_mode = 1'b1;
        repeat (30) begin
            send_op(OP_RD_AT, 32'h0, CNT_W'($urandom_range(0, 127)));
        end
        steady_mode = 1'b0;
    endtask

    task automatic test_random_ops();
        int kind;
        int grow_bias;
        int i;
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] pos;
        grow_bias = 30;
        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) steady_mode = ($urandom_range(0, 3) == 0);
            // swing the list between empty and full
            if (i % 80 == 0) grow_bias = $urandom_range(0, 1) ? 70 : 25;
            kind = $urandom_range(0, 99);
            if (kind < 3) begin
                op = OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            end else if (kind < 3 + grow_bias) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_INS_FRONT;
                    1:       op = OP_INS_BACK;
                    default: op = OP_INS_AT;
                endcase
            end else if (kind < 3 + grow_bias + (97 - grow_bias) / 2) begin
                case ($urandom_range(0, 2))
                    0:       op = OP_REM_FRONT;
                    1:       op = OP_REM_BACK;
                    default: op = OP_REM_AT;
                endcase
            end else begin
                case ($urandom_range(0, 2))
                    0:       op = OP_RD_FRONT;
                    1:       op = OP_RD_BACK;
                    default: op = OP_RD_AT;
                endcase
            end
            if ($urandom_range(0, 99) < 10) begin
                pos = CNT_W'($urandom_range(0, 127));
            end else if (op == OP_INS_AT || shadow_len == 0) begin
                pos = CNT_W'($urandom_range(0, shadow_len));
            end else begin
                pos = CNT_W'($urandom_range(0, shadow_len - 1));
            end
            send_op(op, pick_value(), pos);
        end
        steady_mode = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_operation = '0;
        i_value     = '0;
        i_position  = '0;
        shadow_len  = 0;
        fail_count  = 0;
        checked_count = 0;
        longest_list  = 0;
        idle_cycles   = 0;
        steady_mode   = 1'b0;
        hold_req      = 1'b0;
        hold_active   = 1'b0;
        hold_done     = 0;
        foreach (status_seen[k]) status_seen[k] = 0;
        foreach (shadow_cells[k]) shadow_cells[k] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_empty_list();
        test_edge_positions();
        test_full_list();
        test_backpressure();
        test_random_ops();

        i_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: ok %0d, full %0d, empty %0d, out of range %0d",
                 checked_count, status_seen[ST_OK], status_seen[ST_FULL],
                 status_seen[ST_EMPTY], status_seen[ST_RANGE]);
        $display("List grew to %0d entries; output held off for %0d cycles",
                 longest_list, hold_done);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
